@@ sv/websocket_frame_deframer_top_defines.svh @@
// Assertion macros for the WebSocket frame deframer.
`ifndef WEBSOCKET_FRAME_DEFRAMER_TOP_DEFINES_SVH
`define WEBSOCKET_FRAME_DEFRAMER_TOP_DEFINES_SVH

// Clocked assertion, disabled while reset is asserted
`define WSFD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds during reset
`define WSFD_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ sv/wsfd_pkg.sv @@
// Shared constants for the WebSocket frame deframer.
package wsfd_pkg;

    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned OPCODE_W   = 4;
    localparam int unsigned LENGTH_W   = 64;
    localparam int unsigned HDR_CNT_W  = 3;
    localparam int unsigned KEY_BYTES  = 4;

    // Second header byte length codes
    localparam logic [6:0] MAX_SHORT_LEN = 7'd125;
    localparam logic [6:0] LEN16_CODE    = 7'd126;

    // Last extended-length and masking-key byte indices
    localparam logic [HDR_CNT_W-1:0] EXT16_LAST = 3'd1;
    localparam logic [HDR_CNT_W-1:0] EXT64_LAST = 3'd7;
    localparam logic [1:0]           KEY_LAST   = 2'd3;

endpackage

@@ sv/websocket_frame_deframer_top.sv @@
// WebSocket frame deframer top level: header parser and payload unmasker.
//
// Usage:
//   Input channel (in_valid/in_ready, in_byte) carries one byte of a stream
//   of back-to-back WebSocket frames per transaction. Output channel
//   (out_valid/out_ready) carries one result per payload byte, with the
//   frame's header fields alongside; a zero-length frame gives a single
//   result with has_data clear and last_in_frame set.
//   Path: a byte is taken into an input register, then decoded by the
//   header/payload state machine into the result register. Header bytes
//   give no result except the one that completes an empty frame's header.
//   Throughput: one byte per cycle unless a result waits on out_ready, set by the
//   parser (64-bit length shift and payload count increment/compare).
//   Stall: while a result waits on out_ready, one more byte is held in the
//   input register; header bytes that give no result keep draining.
//   Reset: rst_n clears the parser to await a first header byte and
//   empties both registers; the masking key and length read as zero.
`include "websocket_frame_deframer_top_defines.svh"

module websocket_frame_deframer_top (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [wsfd_pkg::BYTE_W-1:0]   in_byte,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [wsfd_pkg::BYTE_W-1:0]   data_byte,
    output logic                          fin,
    output logic [wsfd_pkg::OPCODE_W-1:0] opcode,
    output logic                          masked,
    output logic [wsfd_pkg::LENGTH_W-1:0] payload_length,
    output logic                          has_data,
    output logic                          last_in_frame
);
    import wsfd_pkg::*;

    typedef enum logic [2:0] {
        PH_HDR0  = 3'd0,
        PH_HDR1  = 3'd1,
        PH_EXT16 = 3'd2,
        PH_EXT64 = 3'd3,
        PH_MASK  = 3'd4,
        PH_DATA  = 3'd5
    } phase_t;

    // Input register
    logic                  in_valid_reg;
    logic [BYTE_W-1:0]     in_byte_reg;

    // Parser state
    phase_t                phase_reg, phase_next;
    logic                  fin_reg, fin_next;
    logic [OPCODE_W-1:0]   opcode_reg, opcode_next;
    logic                  mask_reg, mask_next;
    logic [HDR_CNT_W-1:0]  hdr_cnt_reg, hdr_cnt_next;
    logic [LENGTH_W-1:0]   length_reg, length_next;
    logic [BYTE_W-1:0]     key_reg [KEY_BYTES];
    logic [BYTE_W-1:0]     key_next [KEY_BYTES];
    logic [LENGTH_W-1:0]   pcount_reg, pcount_next;

    // Result register
    logic                  out_valid_reg;
    logic [BYTE_W-1:0]     data_reg;
    logic                  fin_out_reg;
    logic [OPCODE_W-1:0]   opcode_out_reg;
    logic                  mask_out_reg;
    logic [LENGTH_W-1:0]   length_out_reg;
    logic                  has_data_reg;
    logic                  last_reg;

    // Decode outputs
    logic                  emit;
    logic [BYTE_W-1:0]     e_data;
    logic                  e_has;
    logic                  e_last;
    logic                  advance;
    logic [LENGTH_W-1:0]   pcount_inc;

    assign pcount_inc = pcount_reg + LENGTH_W'(1);

    // Next-state decode of the byte in the input register
    always_comb
    begin
        phase_next   = phase_reg;
        fin_next     = fin_reg;
        opcode_next  = opcode_reg;
        mask_next    = mask_reg;
        hdr_cnt_next = hdr_cnt_reg;
        length_next  = length_reg;
        key_next     = key_reg;
        pcount_next  = pcount_reg;
        emit         = 1'b0;
        e_data       = '0;
        e_has        = 1'b0;
        e_last       = 1'b0;

        unique case (phase_reg)
            PH_HDR1:
            begin
                mask_next    = in_byte_reg[7];
                hdr_cnt_next = '0;
                length_next  = '0;
                if (in_byte_reg[6:0] <= MAX_SHORT_LEN)
                begin
                    length_next = LENGTH_W'(in_byte_reg[6:0]);
                    if (in_byte_reg[7])
                    begin
                        phase_next = PH_MASK;
                    end
                    else
                    begin
                        pcount_next = '0;
                        if (in_byte_reg[6:0] == 7'd0)
                        begin
                            phase_next = PH_HDR0;
                            emit       = 1'b1;
                            e_last     = 1'b1;
                        end
                        else
                        begin
                            phase_next = PH_DATA;
                        end
                    end
                end
                else if (in_byte_reg[6:0] == LEN16_CODE)
                begin
                    phase_next = PH_EXT16;
                end
                else
                begin
                    phase_next = PH_EXT64;
                end
            end
            PH_EXT16, PH_EXT64:
            begin
                length_next = {length_reg[LENGTH_W-BYTE_W-1:0], in_byte_reg};
                if (hdr_cnt_reg == ((phase_reg == PH_EXT16) ? EXT16_LAST : EXT64_LAST))
                begin
                    hdr_cnt_next = '0;
                    if (mask_reg)
                    begin
                        phase_next = PH_MASK;
                    end
                    else
                    begin
                        pcount_next = '0;
                        if (length_next == '0)
                        begin
                            phase_next = PH_HDR0;
                            emit       = 1'b1;
                            e_last     = 1'b1;
                        end
                        else
                        begin
                            phase_next = PH_DATA;
                        end
                    end
                end
                else
                begin
                    hdr_cnt_next = hdr_cnt_reg + HDR_CNT_W'(1);
                end
            end
            PH_MASK:
            begin
                key_next[hdr_cnt_reg[1:0]] = in_byte_reg;
                if (hdr_cnt_reg[1:0] == KEY_LAST)
                begin
                    hdr_cnt_next = '0;
                    pcount_next  = '0;
                    if (length_reg == '0)
                    begin
                        phase_next = PH_HDR0;
                        emit       = 1'b1;
                        e_last     = 1'b1;
                    end
                    else
                    begin
                        phase_next = PH_DATA;
                    end
                end
                else
                begin
                    hdr_cnt_next = hdr_cnt_reg + HDR_CNT_W'(1);
                end
            end
            PH_DATA:
            begin
                // Key index runs over the whole frame
                e_data      = mask_reg ? (in_byte_reg ^ key_reg[pcount_reg[1:0]])
                                       : in_byte_reg;
                e_has       = 1'b1;
                e_last      = (pcount_inc == length_reg);
                emit        = 1'b1;
                pcount_next = pcount_inc;
                if (e_last)
                begin
                    phase_next = PH_HDR0;
                end
            end
            default:
            begin
                // First header byte; RSV bits ignored
                fin_next     = in_byte_reg[7];
                opcode_next  = in_byte_reg[OPCODE_W-1:0];
                hdr_cnt_next = '0;
                phase_next   = PH_HDR1;
            end
        endcase
    end

    // Byte leaves the input register unless its result has nowhere to go
    assign advance  = in_valid_reg && (!emit || !out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    // State, input register and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            phase_reg     <= PH_HDR0;
            fin_reg       <= 1'b0;
            opcode_reg    <= '0;
            mask_reg      <= 1'b0;
            hdr_cnt_reg   <= '0;
            length_reg    <= '0;
            for (int i = 0; i < KEY_BYTES; i++)
            begin
                key_reg[i] <= '0;
            end
            pcount_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                in_valid_reg <= in_valid;
            end
            if (advance)
            begin
                phase_reg   <= phase_next;
                fin_reg     <= fin_next;
                opcode_reg  <= opcode_next;
                mask_reg    <= mask_next;
                hdr_cnt_reg <= hdr_cnt_next;
                length_reg  <= length_next;
                key_reg     <= key_next;
                pcount_reg  <= pcount_next;
            end
            if (advance && emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            in_byte_reg <= in_byte;
        end
        if (advance && emit)
        begin
            data_reg       <= e_data;
            fin_out_reg    <= fin_next;
            opcode_out_reg <= opcode_next;
            mask_out_reg   <= mask_next;
            length_out_reg <= length_next;
            has_data_reg   <= e_has;
            last_reg       <= e_last;
        end
    end

    assign out_valid      = out_valid_reg;
    assign data_byte      = data_reg;
    assign fin            = fin_out_reg;
    assign opcode         = opcode_out_reg;
    assign masked         = mask_out_reg;
    assign payload_length = length_out_reg;
    assign has_data       = has_data_reg;
    assign last_in_frame  = last_reg;

    // Checks
    `WSFD_ASSERT(a_empty_is_last, out_valid && !has_data |-> last_in_frame && data_byte == '0,
                 "empty-frame result must be last and carry zero data")
    `WSFD_ASSERT(a_data_count, phase_reg == PH_DATA |-> pcount_reg != length_reg,
                 "payload count reached length without leaving data phase")
    `WSFD_ASSERT_ALWAYS(a_ready_stall, !in_ready |-> in_valid_reg && out_valid_reg && !out_ready,
                        "input stalled without a blocked result")

endmodule

@@ test/tb_websocket_frame_deframer_top.sv @@
// Self-checking testbench for the WebSocket frame deframer: frame stream in, unmasked bytes out.
module tb_websocket_frame_deframer_top;
    import wsfd_pkg::*;

    localparam int          HALF_PERIOD    = 5;
    localparam int          RESET_CYCLES   = 12;
    localparam int          WATCHDOG_LIMIT = 4000;
    localparam int          HOLD_CYCLES    = 300;
    localparam int          DRAIN_CYCLES   = 8;
    localparam int          MAX_REPORTS    = 10;
    localparam logic [6:0]  LEN64_CODE     = 7'd127;

    // Parser phases, mirroring the block's header walk
    typedef enum logic [2:0] {
        AWAIT_HDR0   = 3'd0,
        AWAIT_HDR1   = 3'd1,
        READ_EXT16   = 3'd2,
        READ_EXT64   = 3'd3,
        READ_KEY     = 3'd4,
        READ_PAYLOAD = 3'd5
    } parse_phase_t;

    // Length encodings of the second header byte
    typedef enum logic [1:0] {
        LEN_SHORT = 2'd0,
        LEN_EXT16 = 2'd1,
        LEN_EXT64 = 2'd2
    } len_form_t;

    typedef struct packed {
        logic [BYTE_W-1:0]   data_byte;
        logic                fin;
        logic [OPCODE_W-1:0] opcode;
        logic                masked;
        logic [LENGTH_W-1:0] payload_length;
        logic                has_data;
        logic                last_in_frame;
    } deframe_result_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   in_valid = 1'b0;
    logic                   in_ready;
    logic [BYTE_W-1:0]      in_byte = '0;
    logic                   out_valid;
    logic                   out_ready = 1'b0;
    logic [BYTE_W-1:0]      data_byte;
    logic                   fin;
    logic [OPCODE_W-1:0]    opcode;
    logic                   masked;
    logic [LENGTH_W-1:0]    payload_length;
    logic                   has_data;
    logic                   last_in_frame;

    // Stimulus and scoreboard storage
    logic [BYTE_W-1:0]      byte_stream[$];
    deframe_result_t        expected_bytes[$];
    int                     mismatch_count = 0;
    logic                   in_fire = 1'b0;
    int                     send_idle_pct = 0;
    int                     recv_stall_pct = 0;
    int                     hold_trigger = 0;
    int                     hold_seen = 0;
    int                     hold_left = 0;
    int                     idle_cycles = 0;

    // Shadow parser state
    parse_phase_t           prs_phase = AWAIT_HDR0;
    logic                   prs_fin = 1'b0;
    logic [OPCODE_W-1:0]    prs_opcode = '0;
    logic                   prs_masked = 1'b0;
    logic [HDR_CNT_W-1:0]   prs_hdr_cnt = '0;
    logic [LENGTH_W-1:0]    prs_len = '0;
    logic [BYTE_W-1:0]      prs_key[KEY_BYTES];
    logic [LENGTH_W-1:0]    prs_pay_cnt = '0;

    websocket_frame_deframer_top dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .in_byte        (in_byte),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .data_byte      (data_byte),
        .fin            (fin),
        .opcode         (opcode),
        .masked         (masked),
        .payload_length (payload_length),
        .has_data       (has_data),
        .last_in_frame  (last_in_frame)
    );

    always #HALF_PERIOD clk = ~clk;

    // Length fully known: go to key, payload, or close an empty frame
    function automatic bit header_done();
        prs_hdr_cnt = '0;
        if (prs_masked) begin
            prs_phase = READ_KEY;
            return 1'b0;
        end
        prs_pay_cnt = '0;
        if (prs_len == '0) begin
            prs_phase = AWAIT_HDR0;
            return 1'b1;
        end
        prs_phase = READ_PAYLOAD;
        return 1'b0;
    endfunction

    // Advance the shadow parser by one byte; returns 1 when a result is due
    function automatic bit predict_deframe(input logic [BYTE_W-1:0] b,
                                           output deframe_result_t r);
        bit emit;
        logic [6:0] code;
        emit = 1'b0;
        code = b[6:0];
        r    = '0;
        case (prs_phase)
            AWAIT_HDR1: begin
                prs_masked  = b[7];
                prs_hdr_cnt = '0;
                prs_len     = '0;
                if (code <= MAX_SHORT_LEN) begin
                    prs_len = {57'd0, code};
                    emit    = header_done();
                end
                else begin
                    prs_phase = (code == LEN16_CODE) ? READ_EXT16 : READ_EXT64;
                end
                r.last_in_frame = emit;
            end
            READ_EXT16, READ_EXT64: begin
                prs_len = {prs_len[LENGTH_W-BYTE_W-1:0], b};
                if ((prs_phase == READ_EXT16 && prs_hdr_cnt == EXT16_LAST) ||
                    (prs_phase == READ_EXT64 && prs_hdr_cnt == EXT64_LAST))
                    emit = header_done();
                else
                    prs_hdr_cnt = prs_hdr_cnt + HDR_CNT_W'(1);
                r.last_in_frame = emit;
            end
            READ_KEY: begin
                prs_key[prs_hdr_cnt[1:0]] = b;
                if (prs_hdr_cnt[1:0] == KEY_LAST) begin
                    prs_hdr_cnt = '0;
                    prs_pay_cnt = '0;
                    if (prs_len == '0) begin
                        prs_phase = AWAIT_HDR0;
                        emit      = 1'b1;
                    end
                    else begin
                        prs_phase = READ_PAYLOAD;
                    end
                end
                else begin
                    prs_hdr_cnt = prs_hdr_cnt + HDR_CNT_W'(1);
                end
                r.last_in_frame = emit;
            end
            READ_PAYLOAD: begin
                // key index runs over the whole frame
                r.data_byte     = prs_masked ? (b ^ prs_key[prs_pay_cnt[1:0]]) : b;
                prs_pay_cnt     = prs_pay_cnt + LENGTH_W'(1);
                r.has_data      = 1'b1;
                r.last_in_frame = (prs_pay_cnt == prs_len);
                if (r.last_in_frame)
                    prs_phase = AWAIT_HDR0;
                emit = 1'b1;
            end
            default: begin
                // RSV bits are ignored
                prs_fin     = b[7];
                prs_opcode  = b[3:0];
                prs_hdr_cnt = '0;
                prs_phase   = AWAIT_HDR1;
            end
        endcase
        r.fin            = prs_fin;
        r.opcode         = prs_opcode;
        r.masked         = prs_masked;
        r.payload_length = prs_len;
        return emit;
    endfunction

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (got !== want) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
                $display("mismatch on %s: expected %0h, got %0h", name, want, got);
        end
    endtask

    // Queue one frame; send_len payload bytes actually go out
    task automatic add_frame(input logic fin_bit, input logic [2:0] rsv,
                             input logic [3:0] op, input logic msk,
                             input len_form_t form, input logic [63:0] len,
                             input int send_len);
        logic [6:0] code;
        case (form)
            LEN_SHORT: code = len[6:0];
            LEN_EXT16: code = LEN16_CODE;
            default:   code = LEN64_CODE;
        endcase
        byte_stream.push_back({fin_bit, rsv, op});
        byte_stream.push_back({msk, code});
        if (form == LEN_EXT16) begin
            byte_stream.push_back(len[15:8]);
            byte_stream.push_back(len[7:0]);
        end
        else if (form == LEN_EXT64) begin
            for (int i = 7; i >= 0; i--)
                byte_stream.push_back(len[i*8 +: 8]);
        end
        if (msk) begin
            for (int i = 0; i < KEY_BYTES; i++)
                byte_stream.push_back(8'($urandom_range(0, 255)));
        end
        for (int i = 0; i < send_len; i++)
            byte_stream.push_back(8'($urandom_range(0, 255)));
    endtask

    // Well-formed frame with random header fields, mostly short payloads
    task automatic add_random_frame();
        int        sel;
        int        pick;
        len_form_t form;
        logic [63:0] len;
        sel  = $urandom_range(0, 99);
        pick = $urandom_range(0, 99);
        if (sel < 60) begin
            form = LEN_SHORT;
            if (pick < 10)      len = '0;
            else if (pick < 13) len = 64'(MAX_SHORT_LEN);
            else if (pick < 20) len = 64'($urandom_range(0, 125));
            else                len = 64'($urandom_range(1, 16));
        end
        else begin
            form = (sel < 85) ? LEN_EXT16 : LEN_EXT64;
            if (pick < 10)      len = '0;
            else if (pick < 30) len = 64'($urandom_range(1, 125));
            else                len = 64'($urandom_range(126, 300));
        end
        add_frame(1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)),
                  4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)),
                  form, len, int'(len));
    endtask

    task automatic wait_drained();
        while (byte_stream.size() != 0 || in_valid || expected_bytes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic run_random(input int send_pct, input int recv_pct, input int n_bytes);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        while (byte_stream.size() < n_bytes)
            add_random_frame();
        wait_drained();
    endtask

    // Sender: offers the next pending byte, holds it until the transaction
    always @(negedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end
        else if (!in_valid || in_fire) begin
            if (byte_stream.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                in_valid <= 1'b1;
                in_byte  <= byte_stream.pop_front();
            end
            else begin
                in_valid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls, plus a long hold-off when requested
    always @(negedge clk) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
        end
        else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end
        else if (hold_seen != hold_trigger) begin
            hold_seen <= hold_trigger;
            hold_left <= HOLD_CYCLES;
            out_ready <= 1'b0;
        end
        else begin
            out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // Monitor: check results first, then predict from the accepted byte
    always @(posedge clk) begin : monitor
        deframe_result_t want;
        deframe_result_t got;
        if (!rst_n) begin
            in_fire <= 1'b0;
        end
        else begin
            if (out_valid && out_ready) begin
                got = '{data_byte, fin, opcode, masked, payload_length,
                        has_data, last_in_frame};
                if (expected_bytes.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("unexpected result: data %0h last %0b",
                                 data_byte, last_in_frame);
                end
                else begin
                    want = expected_bytes.pop_front();
                    check_field("data_byte", 64'(want.data_byte), 64'(got.data_byte));
                    check_field("fin", 64'(want.fin), 64'(got.fin));
                    check_field("opcode", 64'(want.opcode), 64'(got.opcode));
                    check_field("masked", 64'(want.masked), 64'(got.masked));
                    check_field("payload_length", want.payload_length,
                                got.payload_length);
                    check_field("has_data", 64'(want.has_data), 64'(got.has_data));
                    check_field("last_in_frame", 64'(want.last_in_frame),
                                64'(got.last_in_frame));
                end
            end
            if (in_valid && in_ready) begin
                if (predict_deframe(in_byte, want))
                    expected_bytes.push_back(want);
            end
            in_fire <= in_valid && in_ready;
        end
    end

    // Watchdog: cycles without any transaction
    always @(posedge clk) begin
        if (rst_n) begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("websocket_frame_deframer_top regression: fail");
                $finish;
            end
        end
    end

    initial begin
        for (int i = 0; i < KEY_BYTES; i++)
            prs_key[i] = '0;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: empty frames, RSV bits, non-minimal length
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        add_frame(1'b1, 3'b000, 4'h1, 1'b0, LEN_SHORT, 64'd1, 1);
        add_frame(1'b1, 3'b111, 4'h8, 1'b1, LEN_SHORT, 64'd0, 0);
        add_frame(1'b0, 3'b101, 4'hF, 1'b0, LEN_SHORT, 64'd0, 0);
        add_frame(1'b0, 3'b010, 4'h0, 1'b1, LEN_EXT64, 64'd3, 3);
        wait_drained();

        // Random phases with different idling
        run_random(0, 0, 350);
        run_random(76, 0, 300);
        run_random(0, 76, 300);
        run_random(12, 12, 300);

        // Long receiver hold-off while the sender keeps offering
        hold_trigger++;
        run_random(0, 0, 300);

        // Empty extended frames, then a huge-length frame left open at the end
        add_frame(1'b1, 3'b000, 4'h2, 1'b0, LEN_EXT16, 64'd0, 0);
        add_frame(1'b0, 3'b000, 4'h9, 1'b1, LEN_EXT64, 64'd0, 0);
        add_frame(1'b1, 3'b011, 4'h2, 1'b1, LEN_EXT64,
                  {1'b1, 31'($urandom), 32'($urandom)}, 6);
        run_random(12, 12, 0);

        if (mismatch_count == 0 && expected_bytes.size() == 0)
            $display("websocket_frame_deframer_top regression: pass");
        else
            $display("websocket_frame_deframer_top regression: fail");
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+sv
sv/wsfd_pkg.sv
sv/websocket_frame_deframer_top.sv
test/tb_websocket_frame_deframer_top.sv
